[rtl/core/mpts_pkg.sv]
// mpts_pkg: shared types and constants for the multi-policy task scheduler
// no dependencies
`timescale 1ns / 1ps
package mpts_pkg;
  localparam int NUM_TASKS = 4;
  localparam int TW = 3;
  localparam logic [31:0] SHIFT_SEED = 32'h9908B0DF;

  localparam logic [2:0] ACT_SCHED = 3'd0;
  localparam logic [2:0] ACT_EXIT  = 3'd1;
  localparam logic [2:0] ACT_PRIO  = 3'd2;
  localparam logic [2:0] ACT_SHARE = 3'd3;
  localparam logic [2:0] ACT_TICK  = 3'd4;

  localparam logic [2:0] POL_RR    = 3'd0;
  localparam logic [2:0] POL_LOW   = 3'd1;
  localparam logic [2:0] POL_PRIO  = 3'd2;
  localparam logic [2:0] POL_SHARE = 3'd3;
  localparam logic [2:0] POL_LOT   = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_DIV, ST_PICK, ST_OUT
  } state_t;

  // divider control and status
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [9:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic       done;
    logic [9:0] rem;
  } div_rsp_t;
endpackage

[rtl/core/mpts_div.sv]
// mpts_div: bit-serial restoring remainder unit, one dividend bit a cycle
// depends on mpts_pkg
`timescale 1ns / 1ps
module mpts_div (
  input  logic               clk,
  input  logic               rst_n,
  input  mpts_pkg::div_req_t req,
  output mpts_pkg::div_rsp_t rsp
);
  import mpts_pkg::*;
  logic        busy_r, busy_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [31:0] q_r, q_nxt;
  logic [9:0]  rem_r, rem_nxt, d_r, d_nxt;
  logic [10:0] trial;

  // one shift-subtract step
  always_comb begin
    busy_nxt = busy_r; cnt_nxt = cnt_r; q_nxt = q_r; rem_nxt = rem_r; d_nxt = d_r;
    trial = {rem_r, q_r[31]};
    if (req.start) begin
      busy_nxt = 1'b1; cnt_nxt = 6'd0; q_nxt = req.dividend; rem_nxt = '0;
      d_nxt = req.divisor;
    end else if (busy_r) begin
      q_nxt = {q_r[30:0], 1'b0};
      rem_nxt = (trial >= {1'b0, d_r}) ? 10'(trial - {1'b0, d_r}) : trial[9:0];
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd31) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; rem_r <= rem_nxt; d_r <= d_nxt;
  end

  assign rsp.done = busy_r && cnt_r == 6'd31;
  assign rsp.rem  = rem_nxt;
endmodule

[rtl/core/multi_policy_task_scheduler.sv]
// multi_policy_task_scheduler: top level, state, sequencer and task scan
// depends on mpts_pkg and mpts_div
`timescale 1ns / 1ps
// Schedules four tasks under one of five policies.
// Channels: in_* carries one event (in_tuser action, in_tdata value), out_*
// returns one grant per event (out_tdata granted_task, out_tuser idle),
// cfg_* writes the 3-bit policy mode.
// An event is scanned one task a cycle through a single compare unit.
// The result is valid after the scan and the pick step have run; a lottery
// draw adds a serial remainder and a second scan.
// One event is in flight at a time; in_tready is high only while the sequencer
// waits for an event, and the next event is taken once the sequencer has
// returned from the output state to idle after the result transaction.
// The result sits in an output register until taken; a stalled receiver
// holds the sequencer and so in_tready stays low.
// Reset (synchronous, rst_n low) makes every task runnable with priority and
// share equal to its index, clears share counts and tickets, seeds the shift
// register, sets the current task to 1 and the policy to round robin.
// cfg_ready is always high; write only while idle.
module multi_policy_task_scheduler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] value
  input  logic [2:0]  in_tuser,   // [2:0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [2:0] granted_task
  output logic        out_tuser   // [0] idle
);
  import mpts_pkg::*;

  state_t state_r, state_nxt;
  logic [2:0] mode_r;
  logic [NUM_TASKS:1] live_r, tset_r;
  logic [7:0] prio_r [NUM_TASKS:1];
  logic [7:0] share_r [NUM_TASKS:1];
  logic [7:0] used_r [NUM_TASKS:1];
  logic [7:0] tick_r [NUM_TASKS:1];
  logic [31:0] rnd_r;
  logic [TW-1:0] cur_r;
  logic [2:0] act_r;
  logic [TW-1:0] idx_r, pick_r, alt_r;
  logic [8:0] best_r;
  logic [9:0] sum_r, ticket_r;
  logic phase_r;
  logic [TW-1:0] res_task_r;
  logic res_idle_r, ovalid_r;
  div_req_t dreq;
  div_rsp_t drsp;

  mpts_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign cfg_ready  = 1'b1;
  assign in_tready  = state_r == ST_IDLE;
  assign out_tvalid = ovalid_r;
  assign out_tdata  = {5'd0, res_task_r};
  assign out_tuser  = res_idle_r;

  // shift register step: shift right, feedback into bit 15
  logic [31:0] rnd_step;
  assign rnd_step = {1'b0, rnd_r[31:1]}
                    | {16'd0, (rnd_r[0]^rnd_r[2]^rnd_r[3]^rnd_r[5]), 15'd0};

  // per-task view of the scanned task
  logic [TW-1:0] t;
  logic t_live, t_sok;
  logic [9:0] tally_hi;
  assign t = idx_r;
  assign t_live = live_r[t];
  assign t_sok = t_live && (used_r[t] == 0 || used_r[t] < share_r[t]);
  assign tally_hi = sum_r + {2'd0, tick_r[t]};
  logic cur_live;
  assign cur_live = live_r[cur_r];
  logic scan_last;
  assign scan_last = idx_r == TW'(NUM_TASKS);

  // lottery totals including the task scanned this cycle
  logic lot_hit;
  logic [9:0] lot_sum;
  logic lot_draw;
  assign lot_hit  = t_live && !tset_r[t];
  assign lot_sum  = (t_live && pick_r == 0) ? tally_hi : sum_r;
  assign lot_draw = mode_r == POL_LOT && act_r <= ACT_EXIT && !phase_r && pick_r == 0
                    && !lot_hit && lot_sum != 0;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_tvalid) state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (scan_last) state_nxt = lot_draw ? ST_DIV : ST_PICK;
      end
      ST_DIV:  if (drsp.done) state_nxt = ST_SCAN;
      ST_PICK: state_nxt = ST_OUT;
      ST_OUT:  if (!ovalid_r) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign dreq.start = state_r == ST_SCAN && state_nxt == ST_DIV;
  assign dreq.dividend = rnd_step;
  assign dreq.divisor = lot_sum;

  // grant of the event, computed on the pick step
  logic [TW-1:0] fin_task;
  always_comb begin
    fin_task = '0;
    if (act_r > ACT_EXIT) fin_task = cur_live ? cur_r : '0;
    else case (mode_r) inside
      POL_RR, POL_LOW, POL_PRIO, POL_LOT: fin_task = pick_r;
      POL_SHARE: fin_task = pick_r != 0 ? pick_r : alt_r;
      default: fin_task = '0;
    endcase
  end

  integer k;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; mode_r <= POL_RR; live_r <= '1; tset_r <= '0;
      rnd_r <= SHIFT_SEED; cur_r <= TW'(1); ovalid_r <= 1'b0;
      for (k = 1; k <= NUM_TASKS; k++) begin
        prio_r[k] <= 8'(k); share_r[k] <= 8'(k); used_r[k] <= '0; tick_r[k] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) mode_r <= cfg_data;
      if (ovalid_r && out_tready) ovalid_r <= 1'b0;
      unique case (state_r)
        // accept the event, apply set or exit
        ST_IDLE: if (in_tvalid) begin
          act_r <= in_tuser; idx_r <= TW'(1); pick_r <= '0; alt_r <= '0;
          best_r <= 9'd256; sum_r <= '0; phase_r <= 1'b0;
          unique case (in_tuser)
            ACT_EXIT:  live_r[cur_r] <= 1'b0;
            ACT_PRIO:  prio_r[cur_r] <= in_tdata;
            ACT_SHARE: begin share_r[cur_r] <= in_tdata; used_r[cur_r] <= '0; end
            ACT_TICK:  begin tick_r[cur_r] <= in_tdata; tset_r[cur_r] <= 1'b1; end
            default: ;
          endcase
        end
        // one task per cycle through the shared compare
        ST_SCAN: begin
          if (!scan_last) idx_r <= idx_r + TW'(1);
          if (t_live) case (mode_r)
            POL_RR: if (t > cur_r && (pick_r == 0 || pick_r <= cur_r)) pick_r <= t;
                    else if (t <= cur_r && pick_r == 0) pick_r <= t;
            POL_LOW: if (pick_r == 0) pick_r <= t;
            POL_PRIO: if ({1'b0, prio_r[t]} < best_r) begin
              best_r <= {1'b0, prio_r[t]}; pick_r <= t;
            end
            POL_SHARE: begin
              if (t_sok && (pick_r == 0 || t == cur_r)) pick_r <= t;
              if (alt_r == 0 || t == cur_r + TW'(1)) alt_r <= t;
            end
            POL_LOT: if (!phase_r) begin
              if (!tset_r[t] && pick_r == 0 && alt_r == 0) pick_r <= t;
              if (pick_r == 0) sum_r <= tally_hi;
            end else if (pick_r == 0) begin
              if (sum_r <= ticket_r && tally_hi > ticket_r) pick_r <= t;
              sum_r <= tally_hi;
            end
            default: ;
          endcase
          if (scan_last && lot_draw) rnd_r <= rnd_step;
        end
        // remainder done, rescan for the winning range
        ST_DIV: if (drsp.done) begin
          ticket_r <= drsp.rem; phase_r <= 1'b1; idx_r <= TW'(1); sum_r <= '0;
        end
        ST_PICK: begin
          res_task_r <= fin_task; res_idle_r <= fin_task == 0; ovalid_r <= 1'b1;
          if (fin_task != 0) cur_r <= fin_task;
          if (act_r <= ACT_EXIT && mode_r == POL_SHARE) begin
            if (pick_r != 0) used_r[pick_r] <= used_r[pick_r] + 8'd1;
            else begin
              for (k = 1; k <= NUM_TASKS; k++)
                used_r[k] <= (TW'(k) == fin_task) ? 8'd1 : 8'd0;
            end
          end
        end
        ST_OUT: ;
        default: ;
      endcase
    end
  end

  // assertions
  a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid || out_tready || state_r == ST_IDLE) else $error("overlap");
  a_idle_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == (out_tdata[2:0] == 3'd0))) else $error("idle mismatch");
  a_cur_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_r != 0 && cur_r <= TW'(NUM_TASKS)) else $error("current task out of range");
endmodule
